FILE: design/ppmsd_pkg.sv
// Shared types, constants and register codes for the PPM-sum pulse decoder.
package ppmsd_pkg;

	localparam int CHANNELS_DEF  = 12;
	localparam int TIME_BITS_DEF = 16;

	localparam int MAP_SLOTS   = 12;
	localparam int GOOD_CH     = 4;
	localparam int ADDR_W      = 6;
	localparam int DATA_W      = 64;

	localparam logic [11:0] WIDTH_RESET = 12'd1502;
	localparam logic [3:0]  GOOD_ALL    = 4'hF;

	localparam logic [15:0] SYNC_GAP_RESET  = 16'd3000;
	localparam logic [11:0] MIN_PULSE_RESET = 12'd900;
	localparam logic [11:0] MAX_PULSE_RESET = 12'd2200;
	localparam logic [11:0] GOOD_THR_RESET  = 12'd985;

	typedef enum logic [2:0] {
		REG_SYNC_GAP    = 3'd0,
		REG_MIN_PULSE   = 3'd1,
		REG_MAX_PULSE   = 3'd2,
		REG_GOOD_THR    = 3'd3,
		REG_FAILSAFE_EN = 3'd4,
		REG_CHANNEL_MAP = 3'd5
	} reg_idx_t;

	typedef enum logic {
		MODE_EDGE = 1'b0,
		MODE_READ = 1'b1
	} mode_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] timestamp;
		logic [3:0]  read_index;
	} evt_t;

	typedef struct packed {
		logic [11:0] read_data;
		logic        sync_seen;
		logic        stored;
		logic [3:0]  channel;
		logic        frame_good;
	} res_t;

	typedef struct packed {
		logic [15:0]         sync_gap;
		logic [11:0]         min_pulse;
		logic [11:0]         max_pulse;
		logic [11:0]         good_threshold;
		logic                failsafe_enable;
		logic [11:0][3:0]    channel_map;
	} cfg_t;

endpackage

FILE: design/ppmsd_regs.sv
// APB configuration register file for the PPM-sum pulse decoder.
module ppmsd_regs
	import ppmsd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_gap        <= SYNC_GAP_RESET;
			cfg_q.min_pulse       <= MIN_PULSE_RESET;
			cfg_q.max_pulse       <= MAX_PULSE_RESET;
			cfg_q.good_threshold  <= GOOD_THR_RESET;
			cfg_q.failsafe_enable <= 1'b1;
			cfg_q.channel_map     <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_SYNC_GAP:    cfg_q.sync_gap        <= pwdata[15:0];
				REG_MIN_PULSE:   cfg_q.min_pulse       <= pwdata[11:0];
				REG_MAX_PULSE:   cfg_q.max_pulse       <= pwdata[11:0];
				REG_GOOD_THR:    cfg_q.good_threshold  <= pwdata[11:0];
				REG_FAILSAFE_EN: cfg_q.failsafe_enable <= pwdata[0];
				REG_CHANNEL_MAP: cfg_q.channel_map     <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_SYNC_GAP:    prdata = DATA_W'(cfg_q.sync_gap);
			REG_MIN_PULSE:   prdata = DATA_W'(cfg_q.min_pulse);
			REG_MAX_PULSE:   prdata = DATA_W'(cfg_q.max_pulse);
			REG_GOOD_THR:    prdata = DATA_W'(cfg_q.good_threshold);
			REG_FAILSAFE_EN: prdata = DATA_W'(cfg_q.failsafe_enable);
			REG_CHANNEL_MAP: prdata = DATA_W'(cfg_q.channel_map);
			default:         prdata = '0;
		endcase
	end

endmodule

FILE: design/ppmsd_decode.sv
// Edge timing state, channel width store and per-item result logic.
module ppmsd_decode
	import ppmsd_pkg::*;
#(
	parameter int CHANNELS  = CHANNELS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  evt_t evt,
	input  logic accept,
	output res_t res
);

	localparam int CNT_W = $clog2(CHANNELS + 1);
	localparam int IDX_W = $clog2(CHANNELS);
	localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;

	logic [TIME_BITS-1:0] last_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [3:0]           mask_q;
	logic [11:0]          widths_q [CHANNELS];

	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS-1:0] diff;
	logic                 is_edge;
	logic                 is_sync;
	logic                 cnt_ok;
	logic                 in_window;
	logic                 do_store;
	logic                 good_hit;
	logic [3:0]           mask_set;
	logic [3:0]           mask_d;
	logic [CNT_W-1:0]     cnt_d;
	logic [3:0]           phys;
	logic                 rd_ok;
	res_t                 res_d;

	assign now       = TIME_BITS'(evt.timestamp);
	assign diff      = now - last_q;
	assign is_edge   = (evt.mode == MODE_EDGE);
	assign is_sync   = CMP_W'(diff) > CMP_W'(cfg.sync_gap);
	assign cnt_ok    = cnt_q < CNT_W'(CHANNELS);
	assign in_window = (TIME_BITS'(cfg.min_pulse) < diff) && (diff < TIME_BITS'(cfg.max_pulse));
	assign do_store  = is_edge && !is_sync && in_window && cnt_ok;
	assign good_hit  = (cnt_q < CNT_W'(GOOD_CH)) && (diff > TIME_BITS'(cfg.good_threshold));
	assign phys      = cfg.channel_map[evt.read_index];
	assign rd_ok     = (evt.read_index < 4'(MAP_SLOTS))
	                && ({1'b0, evt.read_index} < 5'(CHANNELS))
	                && ({1'b0, phys} < 5'(CHANNELS));

	always_comb begin
		mask_set = good_hit ? (4'd1 << cnt_q[1:0]) : 4'd0;
		mask_d   = mask_q;
		cnt_d    = cnt_q;
		res_d    = '0;
		if (!is_edge) begin
			if (rd_ok) begin
				res_d.read_data = widths_q[phys[IDX_W-1:0]];
			end
		end else if (is_sync) begin
			res_d.sync_seen = 1'b1;
			cnt_d           = '0;
		end else begin
			res_d.channel = 4'(cnt_q);
			res_d.stored  = do_store;
			if (do_store && cfg.failsafe_enable) begin
				if ((mask_q | mask_set) == GOOD_ALL) begin
					mask_d           = '0;
					res_d.frame_good = 1'b1;
				end else begin
					mask_d = mask_q | mask_set;
				end
			end
			if (cnt_ok) begin
				cnt_d = cnt_q + CNT_W'(1);
			end
		end
	end

	assign res = res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			cnt_q  <= '0;
			mask_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				widths_q[i] <= WIDTH_RESET;
			end
		end else if (accept && is_edge) begin
			last_q <= now;
			cnt_q  <= cnt_d;
			mask_q <= mask_d;
			if (do_store) begin
				widths_q[cnt_q[IDX_W-1:0]] <= diff[11:0];
			end
		end
	end

endmodule

FILE: design/ppmsd_outreg.sv
// Result register with valid/ready handshake toward the consumer.
module ppmsd_outreg
	import ppmsd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic evt_valid,
	output logic evt_ready,
	output logic accept,
	input  res_t res_d,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	logic valid_q;
	res_t res_q;

	assign evt_ready = !valid_q || res_ready;
	assign accept    = evt_valid && evt_ready;
	assign res_valid = valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

endmodule

FILE: design/ppm_sum_pulse_decoder_core.sv
// Top level of the PPM-sum pulse decoder.
// A result appears in the cycle after its item's transfer, from the result register.
// Throughput: one item per cycle; an item is taken when the result register is empty or its
// result is taken in the same cycle, so a stalled result holds the input back.
// The edge time, channel counter and good mask update at the transfer edge of each edge item.
// Reset clears timing state, counter and good mask, sets every width to 1502,
// and loads the register defaults; no clearing pass is needed.
module ppm_sum_pulse_decoder_core
	import ppmsd_pkg::*;
#(
	parameter int CHANNELS  = CHANNELS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              evt_valid,
	output logic              evt_ready,
	input  evt_t              evt,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res
);

	cfg_t cfg;
	res_t res_d;
	logic accept;

	ppmsd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ppmsd_decode #(
		.CHANNELS  (CHANNELS),
		.TIME_BITS (TIME_BITS)
	) u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.evt    (evt),
		.accept (accept),
		.res    (res_d)
	);

	ppmsd_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.accept    (accept),
		.res_d     (res_d),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

FILE: design/ppmsd_checker.sv
// Port-level checker for the PPM-sum pulse decoder and its bind statement.
module ppmsd_checker
	import ppmsd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic evt_valid,
	input logic evt_ready,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("Result changed or dropped while stalled.");

	a_follow: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready |=> res_valid)
		else $error("Transfer in did not produce a result.");

	a_sync: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.sync_seen |-> res.channel == 4'd0 && !res.stored && !res.frame_good)
		else $error("Sync result carries channel, store or frame flags.");

	a_read: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.read_data != 12'd0 |-> !res.sync_seen && !res.stored
			&& res.channel == 4'd0)
		else $error("Read result carries edge flags.");

	a_good: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.frame_good |-> res.stored && res.channel < 4'(GOOD_CH))
		else $error("Frame good without a store on the first channels.");

endmodule

bind ppm_sum_pulse_decoder_core ppmsd_checker u_ppmsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.evt_valid (evt_valid),
	.evt_ready (evt_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

FILE: tb/tb_ppm_sum_pulse_decoder_core.sv
// Self-checking testbench for the PPM-sum pulse decoder core with directed and random traffic.
module tb_ppm_sum_pulse_decoder_core;
	timeunit 1ns;
	timeprecision 1ps;
	import ppmsd_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int BEYOND_LIST_IDX = 6;
	localparam logic [47:0] IDENTITY_MAP = 48'hBA98_7654_3210;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              evt_valid;
	logic              evt_ready;
	evt_t              evt;
	logic              res_valid;
	logic              res_ready;
	res_t              res;

	ppm_sum_pulse_decoder_core dut (.*);

	cfg_t        cfg;
	logic [15:0] last_ts;
	logic [3:0]  chan_cnt;
	logic [3:0]  good_bits;
	logic [11:0] width_mem [CHANNELS_DEF];

	res_t        pending_results [$];
	logic [15:0] edge_clock;
	int          items_sent;
	int          mismatches;
	int          quiet_cycles;
	int          stall_left;
	bit          idle_on;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic res_t decode_item(evt_t e);
		res_t        r;
		logic [15:0] diff;
		logic [3:0]  c;
		logic [3:0]  phys;
		r = '0;
		if (e.mode == MODE_READ) begin
			if (e.read_index < MAP_SLOTS && e.read_index < CHANNELS_DEF) begin
				phys = cfg.channel_map[e.read_index];
				if (phys < CHANNELS_DEF)
					r.read_data = width_mem[phys];
			end
		end else begin
			diff = e.timestamp - last_ts;
			last_ts = e.timestamp;
			if (diff > cfg.sync_gap) begin
				chan_cnt = '0;
				r.sync_seen = 1'b1;
			end else begin
				c = chan_cnt;
				r.channel = c;
				if (diff > cfg.min_pulse && diff < cfg.max_pulse && c < CHANNELS_DEF) begin
					width_mem[c] = diff[11:0];
					r.stored = 1'b1;
					if (cfg.failsafe_enable) begin
						if (c < GOOD_CH && diff > cfg.good_threshold)
							good_bits[c] = 1'b1;
						if (good_bits == GOOD_ALL) begin
							good_bits = '0;
							r.frame_good = 1'b1;
						end
					end
				end
				if (c < CHANNELS_DEF)
					chan_cnt = c + 4'd1;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin : monitor
		res_t want;
		bit   busy;
		busy = 1'b0;
		if (arst_n) begin
			if (evt_valid && evt_ready) begin
				pending_results.push_back(decode_item(evt));
				busy = 1'b1;
			end
			if (res_valid && res_ready) begin
				busy = 1'b1;
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result transfer %h with none expected", res));
				end else begin
					want = pending_results.pop_front();
					if (res.read_data !== want.read_data)
						report_mismatch($sformatf("read_data got %0d expected %0d",
							res.read_data, want.read_data));
					if (res.sync_seen !== want.sync_seen)
						report_mismatch($sformatf("sync_seen got %b expected %b",
							res.sync_seen, want.sync_seen));
					if (res.stored !== want.stored)
						report_mismatch($sformatf("stored got %b expected %b",
							res.stored, want.stored));
					if (res.channel !== want.channel)
						report_mismatch($sformatf("channel got %0d expected %0d",
							res.channel, want.channel));
					if (res.frame_good !== want.frame_good)
						report_mismatch($sformatf("frame_good got %b expected %b",
							res.frame_good, want.frame_good));
				end
			end
			if (psel && penable)
				busy = 1'b1;
		end
		if (busy) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 60)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		res_ready <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	task automatic send_item(evt_t e);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt <= e;
		evt_valid <= 1'b1;
		do @(posedge clk); while (!evt_ready);
		items_sent++;
	endtask

	task automatic send_edge(int gap_us);
		evt_t e;
		edge_clock = edge_clock + 16'(gap_us);
		e.mode = MODE_EDGE;
		e.timestamp = edge_clock;
		e.read_index = 4'($urandom);
		send_item(e);
	endtask

	task automatic send_read(int idx);
		evt_t e;
		e.mode = MODE_READ;
		e.timestamp = 16'($urandom);
		e.read_index = 4'(idx);
		send_item(e);
	endtask

	task automatic drain();
		evt_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 8);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_SYNC_GAP:    cfg.sync_gap = value[15:0];
			REG_MIN_PULSE:   cfg.min_pulse = value[11:0];
			REG_MAX_PULSE:   cfg.max_pulse = value[11:0];
			REG_GOOD_THR:    cfg.good_threshold = value[11:0];
			REG_FAILSAFE_EN: cfg.failsafe_enable = value[0];
			REG_CHANNEL_MAP: cfg.channel_map = value[47:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(logic [15:0] sync_gap, logic [11:0] min_pulse,
			logic [11:0] max_pulse, logic [11:0] threshold, logic enable, logic [47:0] map);
		drain();
		write_reg(REG_SYNC_GAP, 64'(sync_gap));
		write_reg(REG_MIN_PULSE, 64'(min_pulse));
		write_reg(REG_MAX_PULSE, 64'(max_pulse));
		write_reg(REG_GOOD_THR, 64'(threshold));
		write_reg(REG_FAILSAFE_EN, 64'(enable));
		write_reg(REG_CHANNEL_MAP, 64'(map));
	endtask

	function automatic int pick_sync_gap();
		int lo;
		if (cfg.sync_gap == 16'hFFFF)
			return $urandom_range(0, 65535);
		lo = int'(cfg.sync_gap) + 1;
		return $urandom_range(lo, (lo + 5000 > 65535) ? 65535 : lo + 5000);
	endfunction

	function automatic int pick_pulse();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85 && int'(cfg.max_pulse) > int'(cfg.min_pulse) + 1)
			return $urandom_range(int'(cfg.min_pulse) + 1, int'(cfg.max_pulse) - 1);
		if (r < 95)
			return $urandom_range(0, 4095);
		return $urandom_range(0, 65535);
	endfunction

	function automatic int pick_read_index();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(12, 15);
		return $urandom_range(0, 11);
	endfunction

	task automatic run_traffic(int count);
		int   stop_at;
		int   pick;
		evt_t e;
		stop_at = items_sent + count;
		idle_on = ($urandom_range(0, 3) != 0);
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0)
				idle_on = !idle_on;
			if (pick < 75) begin
				send_edge(pick_sync_gap());
				repeat ($urandom_range(1, 14)) send_edge(pick_pulse());
				repeat ($urandom_range(0, 3)) send_read(pick_read_index());
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 4)) begin
					e = $bits(evt_t)'($urandom);
					if (e.mode == MODE_EDGE)
						edge_clock = e.timestamp;
					send_item(e);
				end
			end else begin
				repeat ($urandom_range(1, 6)) send_read(pick_read_index());
			end
			if ($urandom_range(0, 49) == 0)
				drain();
		end
	endtask

	task automatic test_reset_state();
		send_read(0);
		send_read(12);
		send_read(15);
		send_edge(0);
	endtask

	task automatic test_pulse_window();
		send_edge(int'(SYNC_GAP_RESET) + 1);
		send_edge(int'(SYNC_GAP_RESET));
		send_edge(int'(MIN_PULSE_RESET));
		send_edge(int'(MIN_PULSE_RESET) + 1);
		send_edge(int'(MAX_PULSE_RESET) - 1);
		send_edge(int'(MAX_PULSE_RESET));
		send_read(0);
	endtask

	task automatic test_saturation_and_failsafe();
		send_edge(int'(16'hFFFF - edge_clock));
		repeat (CHANNELS_DEF + 1) send_edge(int'(GOOD_THR_RESET) + 1);
		drain();
	endtask

	task automatic test_channel_map();
		set_config(SYNC_GAP_RESET, MIN_PULSE_RESET, MAX_PULSE_RESET, GOOD_THR_RESET, 1'b1,
			{36'($urandom), 12'h3BF});
		send_read(0);
		send_read(1);
		send_read(2);
		drain();
	endtask

	task automatic test_unlisted_registers();
		write_reg(BEYOND_LIST_IDX, '1);
		write_reg(BEYOND_LIST_IDX + 1, '1);
		run_traffic(20);
		drain();
	endtask

	task automatic test_random_phases();
		set_config(SYNC_GAP_RESET, MIN_PULSE_RESET, MAX_PULSE_RESET, GOOD_THR_RESET, 1'b1,
			IDENTITY_MAP);
		run_traffic(160);
		set_config(16'hFFFF, 12'h000, 12'hFFF, 12'h000, 1'b1, 48'({$urandom, $urandom}));
		run_traffic(120);
		set_config(16'h0000, 12'hFFF, 12'h000, 12'hFFF, 1'b0, '1);
		run_traffic(80);
		set_config(16'($urandom_range(1000, 6000)), 12'($urandom_range(0, 1500)),
			12'($urandom_range(1500, 4095)), 12'($urandom), 1'b0,
			48'({$urandom, $urandom}));
		run_traffic(140);
		repeat (3) begin
			set_config(16'($urandom_range(2500, 9000)), 12'($urandom_range(0, 1200)),
				12'($urandom_range(1800, 4095)), 12'($urandom_range(800, 2000)), 1'b1,
				48'({$urandom, $urandom}));
			run_traffic(140);
		end
		set_config(SYNC_GAP_RESET, MIN_PULSE_RESET, MAX_PULSE_RESET, GOOD_THR_RESET, 1'b1,
			IDENTITY_MAP);
		run_traffic(100);
		drain();
	endtask

	initial begin
		cfg.sync_gap = SYNC_GAP_RESET;
		cfg.min_pulse = MIN_PULSE_RESET;
		cfg.max_pulse = MAX_PULSE_RESET;
		cfg.good_threshold = GOOD_THR_RESET;
		cfg.failsafe_enable = 1'b1;
		cfg.channel_map = '0;
		last_ts = '0;
		chan_cnt = '0;
		good_bits = '0;
		foreach (width_mem[i])
			width_mem[i] = WIDTH_RESET;
		edge_clock = '0;
		items_sent = 0;
		mismatches = 0;
		quiet_cycles = 0;
		idle_on = 1'b1;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		evt_valid <= 1'b0;
		evt <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_pulse_window();
		test_saturation_and_failsafe();
		test_channel_map();
		test_unlisted_registers();
		test_random_phases();

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
